// File: hw/rtl/gamepad_event_qualifier_assert.svh
// assertion macros shared by the gamepad event qualifier rtl
`ifndef GAMEPAD_EVENT_QUALIFIER_ASSERT_SVH
`define GAMEPAD_EVENT_QUALIFIER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked on every rising clock edge outside reset
`define GPQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gamepad event qualifier: same-cycle check failed");
// next-cycle implication
`define GPQ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gamepad event qualifier: next-cycle check failed");
`else
`define GPQ_ASSERT_IMP(label, ante, cons)
`define GPQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/gpq_pkg.sv
// types, codes and constants of the gamepad event qualifier
package gpq_pkg;

   localparam int NUM_BUTTONS = 16;
   localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);

   // command codes
   typedef enum logic [2:0] {
      CMD_BTN_DOWN   = 3'd0,
      CMD_BTN_UP     = 3'd1,
      CMD_HAT        = 3'd2,
      CMD_AXIS       = 3'd3,
      CMD_SEEK_QUERY = 3'd4
   } cmd_type;

   // action codes
   typedef enum logic [4:0] {
      ACT_NONE       = 5'd0,
      ACT_UP         = 5'd1,
      ACT_DOWN       = 5'd2,
      ACT_LEFT       = 5'd3,
      ACT_RIGHT      = 5'd4,
      ACT_SELECT     = 5'd5,
      ACT_BACK       = 5'd6,
      ACT_FAV        = 5'd7,
      ACT_PREV       = 5'd8,
      ACT_NEXT       = 5'd9,
      ACT_SEEK_START = 5'd10,
      ACT_SEEK_END   = 5'd11,
      ACT_MENU       = 5'd12,
      ACT_SHUFFLE    = 5'd13,
      ACT_SUSPEND    = 5'd14,
      ACT_HELP       = 5'd15,
      ACT_VOLUP      = 5'd16,
      ACT_VOLDN      = 5'd17,
      ACT_EXIT       = 5'd18
   } action_type;

   // button indexes
   localparam logic [7:0] BTN_B      = 8'd0;
   localparam logic [7:0] BTN_A      = 8'd1;
   localparam logic [7:0] BTN_Y      = 8'd2;
   localparam logic [7:0] BTN_X      = 8'd3;
   localparam logic [7:0] BTN_L1     = 8'd4;
   localparam logic [7:0] BTN_R1     = 8'd5;
   localparam logic [7:0] BTN_SELECT = 8'd6;
   localparam logic [7:0] BTN_START  = 8'd7;
   localparam logic [7:0] BTN_MENU   = 8'd8;
   localparam logic [7:0] BTN_POWER  = 8'd10;
   localparam logic [7:0] BTN_VOLUP  = 8'd11;
   localparam logic [7:0] BTN_VOLDN  = 8'd12;

   // axis indexes
   localparam logic [7:0] AXIS_STICK_X  = 8'd0;
   localparam logic [7:0] AXIS_STICK_Y  = 8'd1;
   localparam logic [7:0] AXIS_TRIG_L   = 8'd2;
   localparam logic [7:0] AXIS_TRIG_R   = 8'd5;

   // hat values
   localparam logic [3:0] HAT_CENTER = 4'd0;
   localparam logic [3:0] HAT_UP     = 4'd1;
   localparam logic [3:0] HAT_RIGHT  = 4'd2;
   localparam logic [3:0] HAT_DOWN   = 4'd4;
   localparam logic [3:0] HAT_LEFT   = 4'd8;

   // seek direction, two bit signed
   localparam logic [1:0] DIR_NONE  = 2'b00;
   localparam logic [1:0] DIR_RIGHT = 2'b01;
   localparam logic [1:0] DIR_LEFT  = 2'b11;

   // seek acceleration steps
   localparam logic [31:0] HELD_STEP1 = 32'd400;
   localparam logic [31:0] HELD_STEP2 = 32'd1000;
   localparam logic [31:0] HELD_STEP3 = 32'd2000;
   localparam logic signed [6:0] SECS_STEP0 = 7'sd5;
   localparam logic signed [6:0] SECS_STEP1 = 7'sd15;
   localparam logic signed [6:0] SECS_STEP2 = 7'sd30;
   localparam logic signed [6:0] SECS_STEP3 = 7'sd60;

   // register indexes
   localparam logic [2:0] CSR_COOLDOWN     = 3'd0;
   localparam logic [2:0] CSR_TRIG_ON      = 3'd1;
   localparam logic [2:0] CSR_TRIG_OFF     = 3'd2;
   localparam logic [2:0] CSR_STICK_ON     = 3'd3;
   localparam logic [2:0] CSR_STICK_OFF    = 3'd4;
   localparam logic [2:0] CSR_SEEK_INTERVAL = 3'd5;

   // register reset values
   localparam logic [15:0] RST_COOLDOWN      = 16'd250;
   localparam logic [14:0] RST_TRIG_ON       = 15'd4000;
   localparam logic [14:0] RST_TRIG_OFF      = 15'd2000;
   localparam logic [15:0] RST_STICK_ON      = 16'd16000;
   localparam logic [15:0] RST_STICK_OFF     = 16'd8000;
   localparam logic [15:0] RST_SEEK_INTERVAL = 16'd150;

   typedef struct packed {
      logic [15:0] cooldown_ms;
      logic [14:0] trigger_on_level;
      logic [14:0] trigger_off_level;
      logic [15:0] stick_on_level;
      logic [15:0] stick_off_level;
      logic [15:0] seek_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [7:0]         button;
      logic [7:0]         axis_id;
      logic signed [15:0] event_value;
      logic [31:0]        now_ms;
   } item_type;

   typedef struct packed {
      action_type        action;
      logic signed [6:0] seek_amount;
      logic              seeking;
   } result_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] button_pressed;
      logic [1:0][31:0]       press_stamp;
      logic                   start_held;
      logic                   combo_used;
      logic [3:0]             last_hat;
      logic [31:0]            seek_start_ms;
      logic [1:0]             seek_dir;
      logic [31:0]            last_seek_ms;
      logic                   left_trigger_armed;
      logic                   right_trigger_armed;
   } state_type;

endpackage

// File: hw/rtl/gpq_core.sv
// qualifier state and per-event decision logic
`include "gamepad_event_qualifier_assert.svh"

module gpq_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  gpq_pkg::item_type   item,
   input  gpq_pkg::cfg_type    cfg,
   output gpq_pkg::result_type result
);

   gpq_pkg::state_type state_ff;
   gpq_pkg::state_type state_in;

   logic                          tracked;
   logic [gpq_pkg::BTN_IDX_W-1:0] bidx;
   logic                          timed;
   logic                          stamp_sel;
   logic [31:0]                   since_press;
   logic [3:0]                    hat;
   logic signed [15:0]            trig_on;
   logic signed [15:0]            trig_off;
   logic [15:0]                   mag;
   logic                          seek_active;
   logic [31:0]                   held;
   logic [31:0]                   since_seek;
   logic signed [6:0]             secs;

   assign tracked     = item.button < 8'(gpq_pkg::NUM_BUTTONS);
   assign bidx        = item.button[gpq_pkg::BTN_IDX_W-1:0];
   assign timed       = (item.button == gpq_pkg::BTN_START) || (item.button == gpq_pkg::BTN_MENU);
   assign stamp_sel   = (item.button == gpq_pkg::BTN_MENU);
   assign since_press = item.now_ms - state_ff.press_stamp[stamp_sel];
   assign hat         = item.event_value[3:0];
   assign trig_on     = $signed({1'b0, cfg.trigger_on_level});
   assign trig_off    = $signed({1'b0, cfg.trigger_off_level});
   assign mag         = item.event_value[15] ? (~item.event_value + 16'd1) : item.event_value;
   assign seek_active = (state_ff.seek_dir != gpq_pkg::DIR_NONE) && (state_ff.seek_start_ms != '0);
   assign held        = item.now_ms - state_ff.seek_start_ms;
   assign since_seek  = item.now_ms - state_ff.last_seek_ms;

   always_comb begin
      if (held < gpq_pkg::HELD_STEP1) begin
         secs = gpq_pkg::SECS_STEP0;
      end else if (held < gpq_pkg::HELD_STEP2) begin
         secs = gpq_pkg::SECS_STEP1;
      end else if (held < gpq_pkg::HELD_STEP3) begin
         secs = gpq_pkg::SECS_STEP2;
      end else begin
         secs = gpq_pkg::SECS_STEP3;
      end
   end

   always_comb begin
      state_in           = state_ff;
      result.action      = gpq_pkg::ACT_NONE;
      result.seek_amount = '0;
      case (item.cmd)
         gpq_pkg::CMD_BTN_DOWN: begin
            if (tracked && state_ff.button_pressed[bidx]) begin
               result.action = gpq_pkg::ACT_NONE;
            end else if (timed && (since_press < {16'd0, cfg.cooldown_ms})) begin
               // cooldown reject leaves everything alone
               result.action = gpq_pkg::ACT_NONE;
            end else begin
               if (timed) begin
                  state_in.press_stamp[stamp_sel] = item.now_ms;
               end
               if (tracked) begin
                  state_in.button_pressed[bidx] = 1'b1;
               end
               case (item.button)
                  gpq_pkg::BTN_A:      result.action = gpq_pkg::ACT_SELECT;
                  gpq_pkg::BTN_B: begin
                     if (state_ff.start_held) begin
                        state_in.combo_used = 1'b1;
                        result.action       = gpq_pkg::ACT_EXIT;
                     end else begin
                        result.action = gpq_pkg::ACT_BACK;
                     end
                  end
                  gpq_pkg::BTN_X:      result.action = gpq_pkg::ACT_HELP;
                  gpq_pkg::BTN_Y:      result.action = gpq_pkg::ACT_FAV;
                  gpq_pkg::BTN_L1:     result.action = gpq_pkg::ACT_PREV;
                  gpq_pkg::BTN_R1:     result.action = gpq_pkg::ACT_NEXT;
                  gpq_pkg::BTN_SELECT: result.action = gpq_pkg::ACT_SHUFFLE;
                  gpq_pkg::BTN_START: begin
                     state_in.start_held = 1'b1;
                     state_in.combo_used = 1'b0;
                  end
                  gpq_pkg::BTN_MENU:   result.action = gpq_pkg::ACT_MENU;
                  gpq_pkg::BTN_VOLUP:  result.action = gpq_pkg::ACT_VOLUP;
                  gpq_pkg::BTN_VOLDN:  result.action = gpq_pkg::ACT_VOLDN;
                  gpq_pkg::BTN_POWER:  result.action = gpq_pkg::ACT_SUSPEND;
                  default:             result.action = gpq_pkg::ACT_NONE;
               endcase
            end
         end
         gpq_pkg::CMD_BTN_UP: begin
            if (tracked) begin
               state_in.button_pressed[bidx] = 1'b0;
            end
            if (item.button == gpq_pkg::BTN_START) begin
               state_in.start_held = 1'b0;
               state_in.combo_used = 1'b0;
               if (!state_ff.combo_used) begin
                  result.action = gpq_pkg::ACT_MENU;
               end
            end
         end
         gpq_pkg::CMD_HAT: begin
            if (hat != state_ff.last_hat) begin
               state_in.last_hat = hat;
               case (hat)
                  gpq_pkg::HAT_LEFT: begin
                     state_in.seek_start_ms = item.now_ms;
                     state_in.seek_dir      = gpq_pkg::DIR_LEFT;
                     state_in.last_seek_ms  = '0;
                     result.action          = gpq_pkg::ACT_LEFT;
                  end
                  gpq_pkg::HAT_RIGHT: begin
                     state_in.seek_start_ms = item.now_ms;
                     state_in.seek_dir      = gpq_pkg::DIR_RIGHT;
                     state_in.last_seek_ms  = '0;
                     result.action          = gpq_pkg::ACT_RIGHT;
                  end
                  gpq_pkg::HAT_UP: begin
                     state_in.seek_start_ms = '0;
                     state_in.seek_dir      = gpq_pkg::DIR_NONE;
                     result.action          = gpq_pkg::ACT_UP;
                  end
                  gpq_pkg::HAT_DOWN: begin
                     state_in.seek_start_ms = '0;
                     state_in.seek_dir      = gpq_pkg::DIR_NONE;
                     result.action          = gpq_pkg::ACT_DOWN;
                  end
                  gpq_pkg::HAT_CENTER: begin
                     state_in.seek_start_ms = '0;
                     state_in.seek_dir      = gpq_pkg::DIR_NONE;
                  end
                  default: result.action = gpq_pkg::ACT_NONE; // diagonals
               endcase
            end
         end
         gpq_pkg::CMD_AXIS: begin
            if (item.axis_id == gpq_pkg::AXIS_TRIG_L) begin
               if ((item.event_value > trig_on) && !state_ff.left_trigger_armed) begin
                  state_in.left_trigger_armed = 1'b1;
                  result.action               = gpq_pkg::ACT_SEEK_START;
               end else if (item.event_value < trig_off) begin
                  state_in.left_trigger_armed = 1'b0;
               end
            end else if (item.axis_id == gpq_pkg::AXIS_TRIG_R) begin
               if ((item.event_value > trig_on) && !state_ff.right_trigger_armed) begin
                  state_in.right_trigger_armed = 1'b1;
                  result.action                = gpq_pkg::ACT_SEEK_END;
               end else if (item.event_value < trig_off) begin
                  state_in.right_trigger_armed = 1'b0;
               end
            end else if (mag > cfg.stick_on_level) begin
               if (item.axis_id == gpq_pkg::AXIS_STICK_X) begin
                  state_in.seek_start_ms = item.now_ms;
                  state_in.last_seek_ms  = '0;
                  if (item.event_value[15]) begin
                     state_in.seek_dir = gpq_pkg::DIR_LEFT;
                     result.action     = gpq_pkg::ACT_LEFT;
                  end else begin
                     state_in.seek_dir = gpq_pkg::DIR_RIGHT;
                     result.action     = gpq_pkg::ACT_RIGHT;
                  end
               end else if (item.axis_id == gpq_pkg::AXIS_STICK_Y) begin
                  result.action = item.event_value[15] ? gpq_pkg::ACT_UP : gpq_pkg::ACT_DOWN;
               end
            end else if (mag < cfg.stick_off_level) begin
               if ((item.axis_id == gpq_pkg::AXIS_STICK_X) &&
                   (state_ff.seek_dir != gpq_pkg::DIR_NONE)) begin
                  state_in.seek_start_ms = '0;
                  state_in.seek_dir      = gpq_pkg::DIR_NONE;
               end
            end
         end
         gpq_pkg::CMD_SEEK_QUERY: begin
            // a zero last stamp turns the rate limit off
            if (seek_active && !((state_ff.last_seek_ms != '0) &&
                                 (since_seek < {16'd0, cfg.seek_interval_ms}))) begin
               state_in.last_seek_ms = item.now_ms;
               result.seek_amount    = (state_ff.seek_dir == gpq_pkg::DIR_LEFT) ? -secs : secs;
            end
         end
         default: result.action = gpq_pkg::ACT_NONE;
      endcase
      result.seeking = (state_in.seek_dir != gpq_pkg::DIR_NONE) && (state_in.seek_start_ms != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   `GPQ_ASSERT_IMP(combo_needs_start, state_ff.combo_used, state_ff.start_held)
   `GPQ_ASSERT_IMP(idle_seek_has_no_start, state_ff.seek_dir == gpq_pkg::DIR_NONE,
                   state_ff.seek_start_ms == '0)
   `GPQ_ASSERT_NXT(state_holds_without_fire, !fire, $stable(state_ff))

endmodule

// File: hw/rtl/gamepad_event_qualifier.sv
// top level of the gamepad event qualifier: channels, staging and registers
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser cmd, tdata event fields
//  rsp      out        rsp_tvalid/rsp_tready  tdata action, seek amount, seeking
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one transaction per cycle sustained while rsp_tready stays high; each event
// is registered in the input register and then in the result register, around
// the single decision stage in gpq_core
// synchronous active-high reset returns the qualifier state, the configuration
// registers and the valid flags to their defaults, with no clearing pass
// a stalled result holds in the result register while the input register
// still takes one more event; csr writes are always taken
`include "gamepad_event_qualifier_assert.svh"

module gamepad_event_qualifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // button[7:0], axis_id[15:8], event_value[31:16], now_ms[63:32]
   input  logic [2:0]  req_tuser,  // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // action[4:0], seek_amount[11:5], seeking[12], zero[15:13]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration registers
   gpq_pkg::cfg_type cfg_ff;
   gpq_pkg::cfg_type cfg_in;

   // input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   gpq_pkg::item_type item_ff;

   // result stage
   logic                out_valid_ff;
   logic                out_valid_in;
   gpq_pkg::result_type out_ff;
   gpq_pkg::result_type result;

   logic advance;
   logic req_take;

   // the staged event moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gpq_pkg::CSR_COOLDOWN:      cfg_in.cooldown_ms       = csr_data;
            gpq_pkg::CSR_TRIG_ON:       cfg_in.trigger_on_level  = csr_data[14:0];
            gpq_pkg::CSR_TRIG_OFF:      cfg_in.trigger_off_level = csr_data[14:0];
            gpq_pkg::CSR_STICK_ON:      cfg_in.stick_on_level    = csr_data;
            gpq_pkg::CSR_STICK_OFF:     cfg_in.stick_off_level   = csr_data;
            gpq_pkg::CSR_SEEK_INTERVAL: cfg_in.seek_interval_ms  = csr_data;
            default:                    cfg_in = cfg_ff; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_ms       <= gpq_pkg::RST_COOLDOWN;
         cfg_ff.trigger_on_level  <= gpq_pkg::RST_TRIG_ON;
         cfg_ff.trigger_off_level <= gpq_pkg::RST_TRIG_OFF;
         cfg_ff.stick_on_level    <= gpq_pkg::RST_STICK_ON;
         cfg_ff.stick_off_level   <= gpq_pkg::RST_STICK_OFF;
         cfg_ff.seek_interval_ms  <= gpq_pkg::RST_SEEK_INTERVAL;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd         <= req_tuser;
         item_ff.button      <= req_tdata[7:0];
         item_ff.axis_id     <= req_tdata[15:8];
         item_ff.event_value <= $signed(req_tdata[31:16]);
         item_ff.now_ms      <= req_tdata[63:32];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   gpq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.seeking, out_ff.seek_amount, out_ff.action};

   `GPQ_ASSERT_NXT(advance_fills_result, advance, out_valid_ff)
   `GPQ_ASSERT_NXT(blocked_event_kept, in_valid_ff && !advance, in_valid_ff && $stable(item_ff))
   `GPQ_ASSERT_NXT(cooldown_write_lands, csr_valid && (csr_index == gpq_pkg::CSR_COOLDOWN),
                   cfg_ff.cooldown_ms == $past(csr_data))

endmodule
